// File: sv/canonical_reverse_complement_core_defines.svh
// ----------------------------------------------------------------------------
// canonical reverse complement - assertion macros
// shared property wrappers, clocked on clk_i and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef CANONICAL_REVERSE_COMPLEMENT_CORE_DEFINES_SVH
`define CANONICAL_REVERSE_COMPLEMENT_CORE_DEFINES_SVH

// same-cycle implication
`define CANRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CANRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/canrc_pkg.sv
// ----------------------------------------------------------------------------
// canrc_pkg
// shared constants, types and the iupac complement map
// ----------------------------------------------------------------------------
package canrc_pkg;

  // read store capacity
  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW      = $clog2(MAX_LEN + 1);

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ENTRY_W = 2 * BYTE_W;

  // ascii codes, upper case
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_K = 8'h4B;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_U = 8'h55;
  localparam logic [7:0] CH_V = 8'h56;
  localparam logic [7:0] CH_W = 8'h57;
  localparam logic [7:0] CH_Y = 8'h59;
  // or-ing this in gives the lower-case letter
  localparam logic [7:0] LC   = 8'h20;

  // controller to datapath commands
  typedef struct packed {
    logic wr;         // store the accepted element
    logic start;      // last element taken: reset walk index and compare flags
    logic cmp_step;   // compare pass: read one pair, advance index
    logic idx_clr;    // rewind the walk index
    logic emit_load;  // load the output register, advance index
    logic emit_ack;   // output item taken
    logic finish;     // read done: clear fill count and overflow flag
  } canrc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic idx_last;   // walk index points at the last stored element
    logic out_last;   // item held in the output register is the last one
  } canrc_sts_t;

  // iupac complement, case-insensitive, upper-case result
  function automatic logic [7:0] iupac_comp(input logic [7:0] b);
    logic [7:0] r;
    case (b) inside
      CH_A, CH_A | LC:                     r = CH_T;
      CH_C, CH_C | LC:                     r = CH_G;
      CH_G, CH_G | LC:                     r = CH_C;
      CH_T, CH_T | LC, CH_U, CH_U | LC:    r = CH_A;
      CH_M, CH_M | LC:                     r = CH_K;
      CH_R, CH_R | LC:                     r = CH_Y;
      CH_W, CH_W | LC:                     r = CH_W;
      CH_S, CH_S | LC:                     r = CH_S;
      CH_Y, CH_Y | LC:                     r = CH_R;
      CH_K, CH_K | LC:                     r = CH_M;
      CH_V, CH_V | LC:                     r = CH_B;
      CH_H, CH_H | LC:                     r = CH_D;
      CH_D, CH_D | LC:                     r = CH_H;
      CH_B, CH_B | LC:                     r = CH_V;
      default:                             r = CH_N;
    endcase
    return r;
  endfunction

endpackage

// File: sv/canrc_ram.sv
// ----------------------------------------------------------------------------
// canrc_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module canrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]                         rdata_a_o,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]                         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // write port and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: sv/canrc_ctrl.sv
// ----------------------------------------------------------------------------
// canrc_ctrl
// sequencer: load, compare walk, emit walk
// ----------------------------------------------------------------------------
module canrc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               is_last_i,
  output logic               in_stall_o,
  input  logic               out_stall_i,
  input  canrc_pkg::canrc_sts_t sts_i,
  output canrc_pkg::canrc_cmd_t cmd_o
);
  import canrc_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CMP,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_e;

  state_e     state_q, state_d;
  canrc_cmd_t cmd;
  logic       in_acc;

  assign in_acc = in_valid_i && (state_q == ST_LOAD);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      ST_LOAD: begin
        cmd.wr    = in_acc;
        cmd.start = in_acc && is_last_i;
        if (in_acc && is_last_i) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.cmp_step = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.idx_clr = 1'b1;
        state_d     = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd.emit_load = 1'b1;
        state_d       = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        cmd.emit_ack = !out_stall_i;
        if (!out_stall_i) begin
          if (sts_i.out_last) begin
            cmd.finish = 1'b1;
            state_d    = ST_LOAD;
          end else begin
            state_d = ST_EMIT_LD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_LOAD);
  assign cmd_o      = cmd;

endmodule

// File: sv/canrc_dp.sv
// ----------------------------------------------------------------------------
// canrc_dp
// read store, walk index, lexicographic compare and output register
// ----------------------------------------------------------------------------
module canrc_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic [7:0]            base_char_i,
  input  logic [7:0]            quality_char_i,
  input  canrc_pkg::canrc_cmd_t cmd_i,
  output canrc_pkg::canrc_sts_t sts_o,
  output logic                  out_valid_o,
  output logic [7:0]            out_base_o,
  output logic [7:0]            out_quality_o,
  output logic                  out_last_o,
  output logic                  was_flipped_o,
  output logic                  overflowed_o
);
  import canrc_pkg::*;

  logic              mode_q;
  logic [CW-1:0]     fill_q;
  logic              ovf_q;
  logic [CW-1:0]     idx_q;
  logic              flip_q;
  logic              decided_q;
  logic              cmp_vld_q;
  logic              out_valid_q;
  logic [7:0]        out_base_q;
  logic [7:0]        out_qual_q;
  logic              out_last_q;
  logic              out_flip_q;
  logic              out_ovf_q;

  logic              full;
  logic              idx_last;
  logic [CW-1:0]     mirror;
  logic [ENTRY_W-1:0] rd_fwd;
  logic [ENTRY_W-1:0] rd_rev;
  logic [7:0]        fwd_base;
  logic [7:0]        rev_comp;

  assign full     = (fill_q == CW'(MAX_LEN));
  assign idx_last = (idx_q == (fill_q - CW'(1)));
  // mirrored position n-1-i
  assign mirror   = fill_q - CW'(1) - idx_q;

  // element store: port a walks forwards, port b backwards
  canrc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (cmd_i.wr && !full),
    .waddr_i   (fill_q[AW-1:0]),
    .wdata_i   ({base_char_i, quality_char_i}),
    .raddr_a_i (idx_q[AW-1:0]),
    .rdata_a_o (rd_fwd),
    .raddr_b_i (mirror[AW-1:0]),
    .rdata_b_o (rd_rev)
  );

  assign fwd_base = rd_fwd[ENTRY_W-1:BYTE_W];
  assign rev_comp = iupac_comp(rd_rev[ENTRY_W-1:BYTE_W]);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b1;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      flip_q      <= 1'b1;
      decided_q   <= 1'b0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end

      // fill count and overflow flag
      if (cmd_i.wr) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          fill_q <= fill_q + CW'(1);
        end
      end else if (cmd_i.finish) begin
        fill_q <= '0;
        ovf_q  <= 1'b0;
      end

      // walk index
      if (cmd_i.start || cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.cmp_step || cmd_i.emit_load) begin
        idx_q <= idx_q + CW'(1);
      end

      // in canonical mode the first differing byte decides the orientation
      cmp_vld_q <= cmd_i.cmp_step;
      if (cmd_i.start) begin
        flip_q    <= 1'b1;
        decided_q <= 1'b0;
      end else if (cmp_vld_q && mode_q && !decided_q && (fwd_base != rev_comp)) begin
        decided_q <= 1'b1;
        flip_q    <= (fwd_base > rev_comp);
      end

      // output valid
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (cmd_i.emit_ack) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_base_q <= flip_q ? rev_comp : fwd_base;
      out_qual_q <= flip_q ? rd_rev[BYTE_W-1:0] : rd_fwd[BYTE_W-1:0];
      out_last_q <= idx_last;
      out_flip_q <= flip_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign sts_o.idx_last = idx_last;
  assign sts_o.out_last = out_last_q;

  assign out_valid_o   = out_valid_q;
  assign out_base_o    = out_base_q;
  assign out_quality_o = out_qual_q;
  assign out_last_o    = out_last_q;
  assign was_flipped_o = out_flip_q;
  assign overflowed_o  = out_ovf_q;

endmodule

// File: sv/canonical_reverse_complement_core.sv
// ----------------------------------------------------------------------------
// canonical_reverse_complement_core
// stores a read with its quality bytes and emits its iupac reverse complement, or, in
// canonical_mode, the read or its complement, whichever is canonical
// ----------------------------------------------------------------------------
//
//   channel | signals                                              | direction
//   --------+------------------------------------------------------+----------
//   input   | in_valid_i, in_stall_o, base/quality/is_last         | in
//   output  | out_valid_o, out_stall_i, base/quality/last/flip/ovf | out
//   config  | cfg_we_i, cfg_wdata_i (canonical_mode)               | in
//
// loading takes an item whenever the input is open; the last item closes the
// input until the final result of the read has been taken, and the cycle after
// that it opens. for a read: a compare walk (one pair a cycle through the two
// read ports of the store), a rewind, a store read, then per result a store
// read into the output register and a handshake. reset sets canonical_mode
// to 1; output stalls hold the result.
//
module canonical_reverse_complement_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] base_char_i,
  input  logic [7:0] quality_char_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_base_o,
  output logic [7:0] out_quality_o,
  output logic       out_last_o,
  output logic       was_flipped_o,
  output logic       overflowed_o
);
  import canrc_pkg::*;

  canrc_cmd_t cmd;
  canrc_sts_t sts;

  // sequencer
  canrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .is_last_i   (is_last_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // store, compare and output register
  canrc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .base_char_i    (base_char_i),
    .quality_char_i (quality_char_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_base_o     (out_base_o),
    .out_quality_o  (out_quality_o),
    .out_last_o     (out_last_o),
    .was_flipped_o  (was_flipped_o),
    .overflowed_o   (overflowed_o)
  );

endmodule

// File: sv/canrc_checker.sv
// ----------------------------------------------------------------------------
// canrc_checker
// port-level checks on the core, attached by bind
// ----------------------------------------------------------------------------
`include "canonical_reverse_complement_core_defines.svh"

module canrc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic       cfg_wdata_i,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] base_char_i,
  input logic [7:0] quality_char_i,
  input logic       is_last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_base_o,
  input logic [7:0] out_quality_o,
  input logic       out_last_o,
  input logic       was_flipped_o,
  input logic       overflowed_o
);

  // a stalled result stays put
  `CANRC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_base_o) && $stable(out_quality_o) && $stable(out_last_o) && $stable(was_flipped_o) && $stable(overflowed_o), "stalled output item changed")

  // no item is taken while results are going out
  `CANRC_ASSERT_NOW(a_no_load_in_emit, out_valid_o, in_stall_o, "input open during emit")

  // the last item of a read closes the input
  `CANRC_ASSERT_NEXT(a_last_in_stalls, in_valid_i && !in_stall_o && is_last_i, in_stall_o && !out_valid_o, "input open after last item")

  // nothing follows the last result of a read
  `CANRC_ASSERT_NEXT(a_last_out_ends, out_valid_o && !out_stall_i && out_last_o, !out_valid_o && !in_stall_o, "output continued after last item")

endmodule

bind canonical_reverse_complement_core canrc_checker u_canrc_checker (.*);
